// ===== rtl/core/sexpr_token_scanner_unit_macros.svh =====
// Assertion macros used by the checker file sts_checker.
// Each macro samples on the rising edge of clk.
`ifndef SEXPR_TOKEN_SCANNER_UNIT_MACROS_SVH
`define SEXPR_TOKEN_SCANNER_UNIT_MACROS_SVH

// Property that is ignored while rst is high.
`define STS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is checked during reset as well.
`define STS_ASSERT_RESET(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and codes of the S-expression token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int OFFSET_BITS_DEF = 16;

  // Depth of the group queue between scanner and output stage
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] KIND_OPEN   = 4'd0;
  localparam logic [3:0] KIND_CLOSE  = 4'd1;
  localparam logic [3:0] KIND_STRING = 4'd2;
  localparam logic [3:0] KIND_NUMBER = 4'd3;
  localparam logic [3:0] KIND_IDENT  = 4'd4;
  localparam logic [3:0] KIND_BOOL   = 4'd5;
  localparam logic [3:0] KIND_CHAR   = 4'd6;
  localparam logic [3:0] KIND_END    = 4'd7;
  localparam logic [3:0] KIND_ERROR  = 4'd8;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_STRING    = 3'd1;
  localparam logic [2:0] ERR_CHAR_NAME = 3'd2;
  localparam logic [2:0] ERR_HASH      = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        frac;
    logic [7:0]  char_val;
    logic        bool_val;
    logic [2:0]  err;
  } tok_t;

  // All tokens caused by one input byte
  typedef struct packed {
    logic pair;
    tok_t tok_a;
    tok_t tok_b;
  } group_t;

endpackage

// ===== rtl/core/sts_front.sv =====
// ----------------------------------------------------------------------------
// sts_front
// Byte scanner: classifies each accepted byte and pushes the token group it causes, if any.
// ----------------------------------------------------------------------------
module sts_front #(
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_stall,
  input  logic                q_full,
  output logic                push,
  output sts_pkg::group_t     push_data
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_STRING  = 4'd1;
  localparam logic [3:0] M_NUM     = 4'd2;
  localparam logic [3:0] M_NUMDOT  = 4'd3;
  localparam logic [3:0] M_NUMFRAC = 4'd4;
  localparam logic [3:0] M_IDENT   = 4'd5;
  localparam logic [3:0] M_HASH    = 4'd6;
  localparam logic [3:0] M_CHAR    = 4'd7;
  localparam logic [3:0] M_ERROR   = 4'd8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_T   = 8'h54;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  // Character names, left aligned, zero padded
  localparam logic [63:0] TXT_NEWLINE = {"newline", 8'h00};
  localparam logic [63:0] TXT_SPACE   = {"space", 24'h000000};
  localparam logic [63:0] TXT_TAB     = {"tab", 40'h0000000000};
  localparam logic [15:0] LEN_NEWLINE = 16'd7;
  localparam logic [15:0] LEN_SPACE   = 16'd5;
  localparam logic [15:0] LEN_TAB     = 16'd3;
  localparam logic [7:0]  VAL_NEWLINE = 8'd10;
  localparam logic [7:0]  VAL_SPACE   = 8'd32;
  localparam logic [7:0]  VAL_TAB     = 8'd9;

  logic [3:0]             mode, mode_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [OFFSET_BITS-1:0] tbegin, tbegin_next;
  logic [15:0]            tcount, tcount_next;
  logic [7:0]             fbyte, fbyte_next;
  logic [2:0]             nmatch, nmatch_next;
  logic                   frac, frac_next;

  logic                   accept;
  logic                   va, vb, vc;
  sts_pkg::tok_t          ta, tb, tc;

  function automatic logic is_digit(input logic [7:0] ch);
    is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  function automatic logic is_ident(input logic [7:0] ch);
    is_ident = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A)) ||
               (ch == 8'h5F) || (ch == 8'h2B) || (ch == 8'h2D) || (ch == 8'h2A) ||
               (ch == 8'h2F);
  endfunction

  function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
    off_inc = (&v) ? v : v + OFFSET_BITS'(1);
  endfunction

  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    sat16 = (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] len_inc(input logic [15:0] v);
    len_inc = (&v) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] len_add2(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd2;
    len_add2 = s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [7:0] name_char(input logic [63:0] txt, input logic [2:0] pos);
    name_char = txt[{~pos, 3'b000} +: 8];
  endfunction

  function automatic sts_pkg::tok_t mk_tok(input logic [3:0] kind, input logic [15:0] start,
                                           input logic [15:0] len, input logic fr,
                                           input logic [7:0] chv, input logic bv,
                                           input logic [2:0] err);
    sts_pkg::tok_t t;
    t.kind     = kind;
    t.start    = start;
    t.length   = len;
    t.frac     = fr;
    t.char_val = chv;
    t.bool_val = bv;
    t.err      = err;
    mk_tok     = t;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    logic [7:0]             c;
    logic                   restart;
    logic                   do_idle;
    logic                   do_fail;
    logic [2:0]             fcode;
    logic [OFFSET_BITS-1:0] fat;
    logic [15:0]            flen;

    c           = in_byte;
    mode_next   = mode;
    tbegin_next = tbegin;
    tcount_next = tcount;
    fbyte_next  = fbyte;
    nmatch_next = nmatch;
    frac_next   = frac;
    va          = 1'b0;
    vb          = 1'b0;
    vc          = 1'b0;
    ta          = '0;
    tb          = '0;
    tc          = '0;
    restart     = 1'b0;
    do_idle     = 1'b0;
    do_fail     = 1'b0;
    fcode       = sts_pkg::ERR_NONE;
    fat         = offset;
    flen        = 16'd0;

    case (mode)
      M_IDLE: begin
        do_idle = 1'b1;
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          va        = 1'b1;
          ta        = mk_tok(sts_pkg::KIND_STRING, sat16(tbegin), tcount, 1'b0, 8'h00, 1'b0,
                             sts_pkg::ERR_NONE);
          mode_next = M_IDLE;
        end else if (c == CH_NUL) begin
          do_fail = 1'b1;
          fcode   = sts_pkg::ERR_STRING;
        end else begin
          tcount_next = len_inc(tcount);
        end
      end
      M_NUM, M_NUMFRAC: begin
        if (is_digit(c)) begin
          tcount_next = len_inc(tcount);
        end else if ((c == CH_DOT) && (mode == M_NUM)) begin
          mode_next = M_NUMDOT;
        end else begin
          va      = 1'b1;
          ta      = mk_tok(sts_pkg::KIND_NUMBER, sat16(tbegin), tcount, frac, 8'h00, 1'b0,
                           sts_pkg::ERR_NONE);
          do_idle = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (is_digit(c)) begin
          tcount_next = len_add2(tcount);
          frac_next   = 1'b1;
          mode_next   = M_NUMFRAC;
        end else begin
          // Emit the number without its dot, then flag the dot; drop it at end of text
          va      = (c != CH_NUL);
          ta      = mk_tok(sts_pkg::KIND_NUMBER, sat16(tbegin), tcount, frac, 8'h00, 1'b0,
                           sts_pkg::ERR_NONE);
          do_fail = 1'b1;
          fcode   = sts_pkg::ERR_BAD_CHAR;
          fat     = (offset != '0) ? offset - OFFSET_BITS'(1) : '0;
          flen    = 16'd1;
        end
      end
      M_IDENT: begin
        if (is_ident(c) || is_digit(c)) begin
          tcount_next = len_inc(tcount);
        end else begin
          va = 1'b1;
          if ((tcount == 16'd1) && ((fbyte == CH_LOW_T) || (fbyte == CH_LOW_F))) begin
            ta = mk_tok(sts_pkg::KIND_BOOL, sat16(tbegin), 16'd1, 1'b0, 8'h00,
                        fbyte == CH_LOW_T, sts_pkg::ERR_NONE);
          end else begin
            ta = mk_tok(sts_pkg::KIND_IDENT, sat16(tbegin), tcount, 1'b0, 8'h00, 1'b0,
                        sts_pkg::ERR_NONE);
          end
          do_idle = 1'b1;
        end
      end
      M_HASH: begin
        if (c == CH_BSLASH) begin
          mode_next   = M_CHAR;
          tbegin_next = off_inc(offset);
          tcount_next = 16'd0;
          fbyte_next  = 8'h00;
          nmatch_next = 3'b111;
        end else if ((c == CH_LOW_T) || (c == CH_UP_T) || (c == CH_LOW_F) ||
                     (c == CH_UP_F)) begin
          va        = 1'b1;
          ta        = mk_tok(sts_pkg::KIND_BOOL, sat16(tbegin), 16'd2, 1'b0, 8'h00,
                             (c == CH_LOW_T) || (c == CH_UP_T), sts_pkg::ERR_NONE);
          mode_next = M_IDLE;
        end else begin
          do_fail = 1'b1;
          fcode   = sts_pkg::ERR_HASH;
        end
      end
      M_CHAR: begin
        if (is_ident(c)) begin
          // Drop each name that the new byte rules out
          nmatch_next[0] = nmatch[0] && (tcount < LEN_NEWLINE) &&
                           (name_char(TXT_NEWLINE, tcount[2:0]) == c);
          nmatch_next[1] = nmatch[1] && (tcount < LEN_SPACE) &&
                           (name_char(TXT_SPACE, tcount[2:0]) == c);
          nmatch_next[2] = nmatch[2] && (tcount < LEN_TAB) &&
                           (name_char(TXT_TAB, tcount[2:0]) == c);
          if (tcount == 16'd0) begin
            fbyte_next = c;
          end
          tcount_next = len_inc(tcount);
        end else begin
          if (tcount == 16'd1) begin
            va = 1'b1;
            ta = mk_tok(sts_pkg::KIND_CHAR, sat16(tbegin), 16'd1, 1'b0, fbyte, 1'b0,
                        sts_pkg::ERR_NONE);
          end else if (nmatch[0] && (tcount == LEN_NEWLINE)) begin
            va = 1'b1;
            ta = mk_tok(sts_pkg::KIND_CHAR, sat16(tbegin), tcount, 1'b0, VAL_NEWLINE, 1'b0,
                        sts_pkg::ERR_NONE);
          end else if (nmatch[1] && (tcount == LEN_SPACE)) begin
            va = 1'b1;
            ta = mk_tok(sts_pkg::KIND_CHAR, sat16(tbegin), tcount, 1'b0, VAL_SPACE, 1'b0,
                        sts_pkg::ERR_NONE);
          end else if (nmatch[2] && (tcount == LEN_TAB)) begin
            va = 1'b1;
            ta = mk_tok(sts_pkg::KIND_CHAR, sat16(tbegin), tcount, 1'b0, VAL_TAB, 1'b0,
                        sts_pkg::ERR_NONE);
          end
          if (va) begin
            do_idle = 1'b1;
          end else begin
            do_fail = 1'b1;
            fcode   = sts_pkg::ERR_CHAR_NAME;
          end
        end
      end
      default: begin
        // Latched error: ignore bytes until end of text
        mode_next = M_ERROR;
        if (c == CH_NUL) begin
          vb      = 1'b1;
          tb      = mk_tok(sts_pkg::KIND_END, sat16(offset), 16'd0, 1'b0, 8'h00, 1'b0,
                           sts_pkg::ERR_NONE);
          restart = 1'b1;
        end
      end
    endcase

    // Scan the byte as the start of a new token
    if (do_idle) begin
      mode_next = M_IDLE;
      if (c == CH_NUL) begin
        vb      = 1'b1;
        tb      = mk_tok(sts_pkg::KIND_END, sat16(offset), 16'd0, 1'b0, 8'h00, 1'b0,
                         sts_pkg::ERR_NONE);
        restart = 1'b1;
      end else if (c == CH_LPAREN) begin
        vb = 1'b1;
        tb = mk_tok(sts_pkg::KIND_OPEN, sat16(offset), 16'd1, 1'b0, 8'h00, 1'b0,
                    sts_pkg::ERR_NONE);
      end else if (c == CH_RPAREN) begin
        vb = 1'b1;
        tb = mk_tok(sts_pkg::KIND_CLOSE, sat16(offset), 16'd1, 1'b0, 8'h00, 1'b0,
                    sts_pkg::ERR_NONE);
      end else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF)) begin
        mode_next = M_IDLE;
      end else begin
        tbegin_next = offset;
        tcount_next = 16'd1;
        fbyte_next  = c;
        frac_next   = 1'b0;
        if (c == CH_QUOTE) begin
          mode_next   = M_STRING;
          tbegin_next = off_inc(offset);
          tcount_next = 16'd0;
        end else if (c == CH_HASH) begin
          mode_next = M_HASH;
        end else if (is_digit(c)) begin
          mode_next = M_NUM;
        end else if (is_ident(c)) begin
          mode_next = M_IDENT;
        end else begin
          vb        = 1'b1;
          tb        = mk_tok(sts_pkg::KIND_ERROR, sat16(offset), 16'd1, 1'b0, 8'h00, 1'b0,
                             sts_pkg::ERR_BAD_CHAR);
          mode_next = M_ERROR;
        end
      end
    end

    if (do_fail) begin
      vb = 1'b1;
      tb = mk_tok(sts_pkg::KIND_ERROR, sat16(fat), flen, 1'b0, 8'h00, 1'b0, fcode);
      if (c == CH_NUL) begin
        vc      = 1'b1;
        tc      = mk_tok(sts_pkg::KIND_END, sat16(offset), 16'd0, 1'b0, 8'h00, 1'b0,
                         sts_pkg::ERR_NONE);
        restart = 1'b1;
      end else begin
        mode_next = M_ERROR;
      end
    end

    if (restart) begin
      mode_next   = M_IDLE;
      offset_next = '0;
      tbegin_next = '0;
      tcount_next = 16'd0;
      fbyte_next  = 8'h00;
      nmatch_next = 3'b111;
      frac_next   = 1'b0;
    end else begin
      offset_next = off_inc(offset);
    end
  end

  // Pack up to two tokens in order
  always_comb begin
    push_data = '0;
    if (va) begin
      push_data.tok_a = ta;
      push_data.tok_b = vb ? tb : tc;
      push_data.pair  = vb || vc;
    end else if (vb) begin
      push_data.tok_a = tb;
      push_data.tok_b = tc;
      push_data.pair  = vc;
    end else begin
      push_data.tok_a = tc;
      push_data.pair  = 1'b0;
    end
  end

  assign push = accept && (va || vb || vc);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      offset <= '0;
      tbegin <= '0;
      tcount <= 16'd0;
      fbyte  <= 8'h00;
      nmatch <= 3'b111;
      frac   <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      offset <= offset_next;
      tbegin <= tbegin_next;
      tcount <= tcount_next;
      fbyte  <= fbyte_next;
      nmatch <= nmatch_next;
      frac   <= frac_next;
    end
  end

endmodule

// ===== rtl/core/sts_queue.sv =====
// ----------------------------------------------------------------------------
// sts_queue
// Short queue of token groups between the scanner and the output stage.
// ----------------------------------------------------------------------------
module sts_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sts_pkg::group_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output sts_pkg::group_t head
);

  localparam int DEPTH = sts_pkg::QUEUE_DEPTH;
  localparam int PTR   = sts_pkg::QUEUE_PTR_BITS;

  sts_pkg::group_t  slot [DEPTH];
  logic [PTR-1:0]   wptr;
  logic [PTR-1:0]   rptr;
  logic [PTR:0]     cnt;

  assign full  = (cnt == (PTR + 1)'(DEPTH));
  assign empty = (cnt == '0);
  assign head  = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + (PTR + 1)'(1);
        2'b01:   cnt <= cnt - (PTR + 1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/core/sts_back.sv =====
// ----------------------------------------------------------------------------
// sts_back
// Output stage: sends the tokens of each group one per transfer.
// ----------------------------------------------------------------------------
module sts_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  sts_pkg::group_t head,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output sts_pkg::tok_t   out_tok,
  output logic            out_last
);

  logic          half;
  logic          load;
  logic          fin;
  sts_pkg::tok_t sel_tok;

  assign load    = !q_empty && (!out_valid || !out_stall);
  assign fin     = !head.pair || half;
  assign sel_tok = half ? head.tok_b : head.tok_a;
  assign pop     = load && fin;

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= sel_tok;
      out_last <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      half      <= !fin;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/sexpr_token_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// sexpr_token_scanner_unit: streaming S-expr tokenizer, one byte per cycle unless in_stall.
// Path: a byte's tokens go into the group queue, then into the output register.
// Throughput: one byte per cycle unless in_stall; one token per transfer out (4-group queue).
// Reset: rst (synchronous) returns the scanner to idle at offset zero, empties the queue.
// ----------------------------------------------------------------------------
module sexpr_token_scanner_unit #(
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  tok_kind,
  output logic [15:0] tok_start,
  output logic [15:0] tok_length,
  output logic        has_fraction,
  output logic [7:0]  char_value,
  output logic        bool_value,
  output logic [2:0]  error_code,
  output logic        last
);

  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  sts_pkg::group_t push_data;
  sts_pkg::group_t head;
  sts_pkg::tok_t   out_tok;

  sts_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  sts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  sts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_tok   (out_tok),
    .out_last  (last)
  );

  assign tok_kind     = out_tok.kind;
  assign tok_start    = out_tok.start;
  assign tok_length   = out_tok.length;
  assign has_fraction = out_tok.frac;
  assign char_value   = out_tok.char_val;
  assign bool_value   = out_tok.bool_val;
  assign error_code   = out_tok.err;

endmodule

// ===== rtl/core/sts_checker.sv =====
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the token scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "sexpr_token_scanner_unit_macros.svh"

module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  tok_kind,
  input logic [15:0] tok_start,
  input logic [15:0] tok_length,
  input logic        last
);

  `STS_ASSERT_RESET(a_reset_clears_out, rst |=> !out_valid, "output valid after reset")
  `STS_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(tok_kind) && $stable(tok_start) && $stable(tok_length) && $stable(last), "stalled token changed")
  `STS_ASSERT(a_end_is_last, out_valid && (tok_kind == sts_pkg::KIND_END) |-> last, "end token not marked last")
  `STS_ASSERT(a_pair_follows, out_valid && !out_stall && !last |=> out_valid, "second token of a byte not sent next")

endmodule

bind sexpr_token_scanner_unit sts_checker u_sts_checker (.*);
